@@ design/autokey_xor_rotate_cipher_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the autokey XOR-rotate cipher
// Concurrent assertion helpers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef AUTOKEY_XOR_ROTATE_CIPHER_MACROS_SVH
`define AUTOKEY_XOR_ROTATE_CIPHER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define AKXR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("akxr same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define AKXR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("akxr next-cycle check failed");
`else
`define AKXR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define AKXR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ design/akxr_pkg.sv @@
// ----------------------------------------------------------------------------
// akxr_pkg
// Shared constants and types of the autokey XOR-rotate cipher.
// ----------------------------------------------------------------------------
package akxr_pkg;

  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_KEY_WORDS = 8;

  // Configuration port: eight key registers, 32 bits each.
  localparam int CFG_COUNT  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  // Operation controls of the word held in the input stage.
  typedef struct packed {
    logic decrypt;
    logic start;
  } akxr_op_t;

endpackage

@@ design/akxr_in_stage.sv @@
// ----------------------------------------------------------------------------
// akxr_in_stage
// Input register of the cipher; holds one word until the key unit takes it.
// ----------------------------------------------------------------------------
module akxr_in_stage import akxr_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [WORD_BITS-1:0] data_word,
  input  logic                 start_of_message,
  input  logic                 advance,
  output logic                 held_valid,
  output akxr_op_t             held_op,
  output logic [WORD_BITS-1:0] held_data
);

  logic accept;

  // The stage refills in the same cycle that it drains.
  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_op.decrypt <= (func == FUNC_DECRYPT);
      held_op.start   <= start_of_message;
      held_data       <= data_word;
    end
  end

endmodule

@@ design/akxr_key_unit.sv @@
// ----------------------------------------------------------------------------
// akxr_key_unit
// Running key, word index and the per-word XOR, autokey and rotate logic.
// ----------------------------------------------------------------------------
module akxr_key_unit import akxr_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int KEY_WORDS = DEF_KEY_WORDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  advance,
  input  akxr_op_t              op,
  input  logic [WORD_BITS-1:0]  data,
  output logic [WORD_BITS-1:0]  result
);

  localparam int IDX_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int FLAT_W = KEY_WORDS * WORD_BITS;
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(KEY_WORDS - 1);
  localparam logic [CFG_IDX_W:0] CFG_LIMIT = (CFG_IDX_W + 1)'(KEY_WORDS);

  logic [WORD_BITS-1:0] running_key [KEY_WORDS];
  logic [WORD_BITS-1:0] running_key_next [KEY_WORDS];
  logic [IDX_W-1:0]     word_index;
  logic [IDX_W-1:0]     word_index_next;
  logic [IDX_W-1:0]     sel;
  logic [WORD_BITS-1:0] key_word;
  logic [WORD_BITS-1:0] fed_word;
  logic [FLAT_W-1:0]    flat;
  logic [FLAT_W-1:0]    flat_rot;
  logic [WORD_BITS-1:0] cfg_word;
  logic                 cfg_hit;

  generate
    if (WORD_BITS <= CFG_DATA_W) begin : g_cfg_trunc
      assign cfg_word = cfg_data[WORD_BITS-1:0];
    end else begin : g_cfg_ext
      assign cfg_word = {{(WORD_BITS - CFG_DATA_W){1'b0}}, cfg_data};
    end
  endgenerate

  assign cfg_hit = cfg_we && ({1'b0, cfg_index} < CFG_LIMIT);

  assign sel      = op.start ? '0 : word_index;
  assign key_word = running_key[sel];
  assign result   = data ^ key_word;
  // Autokey: the plaintext word is folded into the key word just used.
  assign fed_word = key_word ^ (op.decrypt ? result : data);

  // Word 0 sits at the top of the flat key, so a left rotate carries the
  // top bit of each word into the word before it.
  always_comb begin
    for (int k = 0; k < KEY_WORDS; k++) begin
      flat[(KEY_WORDS - k) * WORD_BITS - 1 -: WORD_BITS] =
        (IDX_W'(k) == sel) ? fed_word : running_key[k];
    end
    flat_rot = {flat[FLAT_W-2:0], flat[FLAT_W-1]};
    for (int k = 0; k < KEY_WORDS; k++) begin
      running_key_next[k] = flat_rot[(KEY_WORDS - k) * WORD_BITS - 1 -: WORD_BITS];
    end
    word_index_next = (sel == LAST_IDX) ? '0 : sel + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_WORDS; k++) begin
        running_key[k] <= '0;
      end
      word_index <= '0;
    end else if (cfg_hit) begin
      running_key[cfg_index[IDX_W-1:0]] <= cfg_word;
    end else if (advance) begin
      running_key <= running_key_next;
      word_index  <= word_index_next;
    end
  end

endmodule

@@ design/akxr_out_stage.sv @@
// ----------------------------------------------------------------------------
// akxr_out_stage
// Result register of the cipher; holds a word until the consumer takes it.
// ----------------------------------------------------------------------------
module akxr_out_stage import akxr_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  input  logic [WORD_BITS-1:0] load_word,
  output logic                 load_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] result_word
);

  logic load;

  assign load_ready = !out_valid || !out_stall;
  assign load       = load_valid && load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_word <= load_word;
    end
  end

endmodule

@@ design/autokey_xor_rotate_cipher.sv @@
// ----------------------------------------------------------------------------
// autokey_xor_rotate_cipher
// An accepted input transaction passes the input register, then the result register.
// Throughput: one word per cycle, unless a stalled output fills both registers.
// Reset: synchronous; clears both stages, the running key and the word index.
// ----------------------------------------------------------------------------
`include "autokey_xor_rotate_cipher_macros.svh"

// The block is a word-wide autokey stream cipher. A running key of KEY_WORDS
// words is kept in flip-flops together with a wrapping word index. Each word
// is XORed with the key word at the index; that key word then absorbs the
// plaintext word, and the whole key rotates left by one bit, word 0 being
// the most significant. A start-of-message flag restarts the index at zero.
//
// Structure: an input register takes a transaction, the key unit processes it
// combinationally as it moves into the result register, and the result
// register holds it for the consumer. Both registers drain and refill in the
// same cycle, so a stalled output only stops the input once both are full.
//
// Writing key register i loads word i of the running key directly; writes are
// to be made while no transaction is in flight, which the block does not check.
module autokey_xor_rotate_cipher import akxr_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int KEY_WORDS = DEF_KEY_WORDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [WORD_BITS-1:0]  data_word,
  input  logic                  start_of_message,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_BITS-1:0]  result_word
);

  logic                 held_valid;
  akxr_op_t             held_op;
  logic [WORD_BITS-1:0] held_data;
  logic [WORD_BITS-1:0] key_result;
  logic                 load_ready;
  logic                 advance;

  // A held word moves on, and updates the key, whenever the result register
  // can take it.
  assign advance = held_valid && load_ready;

  akxr_in_stage #(
    .WORD_BITS(WORD_BITS)
  ) u_in_stage (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (func),
    .data_word        (data_word),
    .start_of_message (start_of_message),
    .advance          (advance),
    .held_valid       (held_valid),
    .held_op          (held_op),
    .held_data        (held_data)
  );

  akxr_key_unit #(
    .WORD_BITS(WORD_BITS),
    .KEY_WORDS(KEY_WORDS)
  ) u_key_unit (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .op        (held_op),
    .data      (held_data),
    .result    (key_result)
  );

  akxr_out_stage #(
    .WORD_BITS(WORD_BITS)
  ) u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (held_valid),
    .load_word   (key_result),
    .load_ready  (load_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_word (result_word)
  );

  // The input side stalls only when both registers are occupied.
  `AKXR_ASSERT_SAME(a_stall_needs_full, clk, rst, in_stall, held_valid && out_valid && out_stall)
  // An accepted transaction is always held in the input register next cycle.
  `AKXR_ASSERT_NEXT(a_accept_held, clk, rst, in_valid && !in_stall, held_valid)
  // A word processed by the key unit always shows up as a result.
  `AKXR_ASSERT_NEXT(a_advance_out, clk, rst, advance, out_valid)
  // A result is withdrawn only after it was delivered.
  `AKXR_ASSERT_SAME(a_drop_after_take, clk, rst, $fell(out_valid), $past(!out_stall))

endmodule

@@ tb/sv/tb_autokey_xor_rotate_cipher.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the autokey XOR-rotate cipher
// Streams encrypt and decrypt word transactions through the block under
// several key settings. A scoreboard class carries its own copy of the
// running key and word index, and checks every result word in order.
// ----------------------------------------------------------------------------

module tb_autokey_xor_rotate_cipher;
  import akxr_pkg::*;

  localparam int WORD_BITS    = DEF_WORD_BITS;
  localparam int KEY_WORDS    = DEF_KEY_WORDS;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int QUIET_LIMIT  = 2000;
  // Settling time after the last result.
  localparam int DRAIN_CYCLES = 6;
  // Share of cycles, in percent, in which each side idles or stalls.
  localparam int IDLE_PCT     = 18;

  // Ways of filling the key registers between phases.
  typedef enum int {
    KEYS_ZERO,
    KEYS_ONES,
    KEYS_ALTERNATE,
    KEYS_WALKING,
    KEYS_RANDOM
  } key_fill_t;

  // The scoreboard keeps its own running key and word index. Every accepted
  // input transaction is pushed through that copy to give the expected
  // result word, which is queued until the block produces its result.
  class cipher_scoreboard;
    logic [WORD_BITS-1:0] key_state [KEY_WORDS];
    int unsigned          word_pos;
    logic [WORD_BITS-1:0] expected_words [$];
    int                   errors;
    int                   words_in;
    int                   decrypts;
    int                   starts;
    int                   key_writes;

    function void reset_state();
      foreach (key_state[k]) key_state[k] = '0;
      word_pos = 0;
    endfunction

    // A key register write loads the word straight into the running key;
    // the word index is left where it is.
    function void load_key(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      key_writes++;
      if (idx < KEY_WORDS) key_state[idx] = WORD_BITS'(val);
    endfunction

    function void note_word(logic f, logic [WORD_BITS-1:0] data, logic som);
      logic [WORD_BITS*KEY_WORDS-1:0] whole;
      logic [WORD_BITS-1:0]           text_out;
      words_in++;
      if (f == FUNC_DECRYPT) decrypts++;
      if (som) begin
        starts++;
        word_pos = 0;
      end
      text_out = data ^ key_state[word_pos];
      // The key word absorbs the plaintext: the input on encrypt, the
      // recovered word on decrypt.
      key_state[word_pos] ^= (f == FUNC_DECRYPT) ? text_out : data;
      // Rotate the whole key left by one bit, word 0 in the top bits.
      for (int k = 0; k < KEY_WORDS; k++)
        whole[(KEY_WORDS-1-k)*WORD_BITS +: WORD_BITS] = key_state[k];
      whole = {whole[WORD_BITS*KEY_WORDS-2:0], whole[WORD_BITS*KEY_WORDS-1]};
      for (int k = 0; k < KEY_WORDS; k++)
        key_state[k] = whole[(KEY_WORDS-1-k)*WORD_BITS +: WORD_BITS];
      word_pos = (word_pos + 1) % KEY_WORDS;
      expected_words.push_back(text_out);
    endfunction

    function void check_result(logic [WORD_BITS-1:0] got);
      logic [WORD_BITS-1:0] want;
      if (expected_words.size() == 0) begin
        $error("result_word arrived with nothing pending: expected none, actual %h", got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        $error("result_word mismatch: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk              = 1'b0;
  logic                  rst              = 1'b1;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic                  func             = FUNC_ENCRYPT;
  logic [WORD_BITS-1:0]  data_word        = '0;
  logic                  start_of_message = 1'b0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [WORD_BITS-1:0]  result_word;

  // When set, neither side idles; one phase runs this way at full rate.
  bit                    calm             = 1'b0;
  int                    quiet_cycles     = 0;

  cipher_scoreboard sb = new();

  autokey_xor_rotate_cipher #(
    .WORD_BITS(WORD_BITS),
    .KEY_WORDS(KEY_WORDS)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .data_word       (data_word),
    .start_of_message(start_of_message),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_word     (result_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The consumer stalls at random, except during the calm phase.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Both handshakes are observed at the rising edge, where the values read
  // are the ones that were settled before the edge. The same process runs
  // the watchdog, which counts cycles in which nothing moves at all.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_word(func, data_word, start_of_message);
      if (out_valid && !out_stall) sb.check_result(result_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Mostly random words, with the extremes turning up now and then.
  function automatic logic [WORD_BITS-1:0] pick_data();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(WORD_BITS-1){1'b0}}};
      3:       return {1'b0, {(WORD_BITS-1){1'b1}}};
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  // Offers one word and returns at the edge where it is taken. A random gap
  // may come first; the valid stays high from one word to the next when none
  // does, so no step sees it lowered and raised again.
  task automatic send_word(logic f, logic [WORD_BITS-1:0] d, logic som);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    func             <= f;
    data_word        <= d;
    start_of_message <= som;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds the sender back until every expected result has come out, then
  // lets the pipeline settle so that key writes find it empty.
  // The first edge lets the monitor record the word taken at the last edge.
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes key registers first..last, one per cycle, with the chosen fill.
  task automatic write_key_set(key_fill_t fill, int first, int last);
    logic [CFG_DATA_W-1:0] val;
    for (int k = first; k <= last; k++) begin
      case (fill)
        KEYS_ZERO:      val = '0;
        KEYS_ONES:      val = '1;
        KEYS_ALTERNATE: val = k[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
        KEYS_WALKING:   val = 32'h1 << (k * 4 + 3);
        default:        val = $urandom;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= k[CFG_IDX_W-1:0];
      cfg_data  <= val;
      @(posedge clk);
      sb.load_key(k[CFG_IDX_W-1:0], val);
    end
    cfg_we <= 1'b0;
  endtask

  // Random traffic. Most of it is whole messages: a start flag on the first
  // word, one direction throughout, lengths that often run past the key
  // length so the index wraps. The rest is loose words with random flags.
  task automatic run_traffic(int items);
    int   sent;
    int   len;
    logic f;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 20) begin
        send_word(1'($urandom_range(1)), pick_data(), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        f   = 1'($urandom_range(1));
        for (int w = 0; w < len; w++) begin
          send_word(f, pick_data(), w == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    sb.reset_state();
    @(posedge clk);

    // Directed words against the all-zero key left by reset: the result
    // equals the input, and the key starts to fill from the data.
    send_word(FUNC_ENCRYPT, 32'h0000_0000, 1'b1);
    send_word(FUNC_ENCRYPT, 32'hFFFF_FFFF, 1'b0);
    send_word(FUNC_DECRYPT, 32'h8000_0000, 1'b0);
    send_word(FUNC_DECRYPT, 32'h0000_0001, 1'b0);
    send_word(FUNC_ENCRYPT, 32'h7FFF_FFFF, 1'b0);
    finish_phase();

    // All-ones key. A ten-word message wraps the word index, then a restart
    // lands part way through the key and a few decrypts follow.
    write_key_set(KEYS_ONES, 0, KEY_WORDS - 1);
    for (int w = 0; w < 10; w++)
      send_word(FUNC_ENCRYPT, 32'h0000_0001 << (w * 3), w == 0);
    send_word(FUNC_ENCRYPT, 32'hDEAD_BEEF, 1'b1);
    send_word(FUNC_DECRYPT, 32'hFFFF_FFFF, 1'b1);
    send_word(FUNC_DECRYPT, 32'h0000_0000, 1'b0);
    send_word(FUNC_DECRYPT, 32'h1234_5678, 1'b0);
    send_word(FUNC_ENCRYPT, 32'hFFFF_FFFF, 1'b0);
    send_word(FUNC_DECRYPT, 32'h8000_0001, 1'b1);
    finish_phase();

    write_key_set(KEYS_ALTERNATE, 0, KEY_WORDS - 1);
    run_traffic(200);
    finish_phase();

    // Full rate on both sides for one long stretch.
    write_key_set(KEYS_RANDOM, 0, KEY_WORDS - 1);
    calm <= 1'b1;
    run_traffic(250);
    calm <= 1'b0;
    finish_phase();

    write_key_set(KEYS_WALKING, 0, KEY_WORDS - 1);
    run_traffic(200);
    finish_phase();

    // Only the middle words are rewritten; the rest of the key and the word
    // index carry over from the previous phase.
    write_key_set(KEYS_RANDOM, 2, 5);
    run_traffic(200);
    finish_phase();

    write_key_set(KEYS_ZERO, 0, KEY_WORDS - 1);
    run_traffic(200);
    finish_phase();

    write_key_set(KEYS_ONES, 0, KEY_WORDS - 1);
    run_traffic(200);
    finish_phase();

    $display("Run covered %0d words (%0d decrypt, %0d with a message start)",
             sb.words_in, sb.decrypts, sb.starts);
    $display("across %0d key register writes in zero, ones, alternating, walking and random fills",
             sb.key_writes);
    if (sb.pending() != 0) begin
      $error("%0d expected result words never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/akxr_pkg.sv
design/akxr_in_stage.sv
design/akxr_key_unit.sv
design/akxr_out_stage.sv
design/autokey_xor_rotate_cipher.sv
tb/sv/tb_autokey_xor_rotate_cipher.sv
